FILE: rtl/bchn_pkg.sv
// Shared types and constants for the bump, cliff and hill navigation controller.
// Holds the input, result and configuration structs and the fixed targets.
// No dependencies.
package bchn_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned LegW     = 14;
  localparam int unsigned SteerW   = 11;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgDriveSpeed   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTurnSpeed    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSlopeEnter   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSlopeExit    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSteerOffset  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgReverseDist  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgHeadingTol   = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgAxisMapping  = 3'd7;

  // Leg targets and turn angle.
  localparam logic [LegW-1:0] LegTargetMax   = 14'd9999;
  localparam logic [LegW-1:0] LegTargetAvoid = 14'd200;
  localparam logic [LegW-1:0] CliffBackupMm  = 14'd100;
  localparam logic [16:0]     TurnDegrees    = 17'd90;

  // Mode codes as shown on the result channel.
  localparam logic [3:0] ModeCodeDrive     = 4'd3;
  localparam logic [3:0] ModeCodeReverse   = 4'd8;
  localparam logic [3:0] ModeCodeLast      = 4'd10;

  typedef struct packed {
    logic               pause_button;
    logic               bump_left;
    logic               bump_center;
    logic               bump_right;
    logic               cliff_left;
    logic               cliff_center;
    logic               cliff_right;
    logic signed [31:0] travelled_mm;
    logic signed [15:0] heading_deg;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
  } in_t;

  typedef struct packed {
    logic signed [15:0] left_wheel_speed;
    logic signed [15:0] right_wheel_speed;
    logic        [3:0]  mode_code;
  } out_t;

  typedef struct packed {
    logic [9:0]  cruise_speed;
    logic [9:0]  spin_speed;
    logic [14:0] slope_enter_level;
    logic [14:0] slope_exit_level;
    logic [8:0]  steer_offset;
    logic [9:0]  reverse_distance;
    logic [7:0]  heading_tolerance;
    logic        axis_mapping;
  } cfg_t;

endpackage

FILE: rtl/bchn_cfg_regs.sv
// Configuration register file for the navigation controller.
// Depends on bchn_pkg for the register indexes and the cfg_t struct.
module bchn_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bchn_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bchn_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output bchn_pkg::cfg_t                 cfg_o
);
  import bchn_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDriveSpeed:  cfg_d.cruise_speed      = cfg_wdata_i[9:0];
        CfgTurnSpeed:   cfg_d.spin_speed        = cfg_wdata_i[9:0];
        CfgSlopeEnter:  cfg_d.slope_enter_level = cfg_wdata_i[14:0];
        CfgSlopeExit:   cfg_d.slope_exit_level  = cfg_wdata_i[14:0];
        CfgSteerOffset: cfg_d.steer_offset      = cfg_wdata_i[8:0];
        CfgReverseDist: cfg_d.reverse_distance  = cfg_wdata_i[9:0];
        CfgHeadingTol:  cfg_d.heading_tolerance = cfg_wdata_i[7:0];
        CfgAxisMapping: cfg_d.axis_mapping      = cfg_wdata_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cruise_speed      <= 10'd225;
      cfg_q.spin_speed        <= 10'd100;
      cfg_q.slope_enter_level <= 15'd205;
      cfg_q.slope_exit_level  <= 15'd82;
      cfg_q.steer_offset      <= 9'd30;
      cfg_q.reverse_distance  <= 10'd50;
      cfg_q.heading_tolerance <= 8'd2;
      cfg_q.axis_mapping      <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/bchn_ctrl.sv
// Navigation state machine with its result register.
// Takes one registered tick, updates the mode and manoeuvre state and
// registers the wheel speeds. Depends on bchn_pkg.
module bchn_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  bchn_pkg::in_t   item_i,
  output logic            item_ready_o,
  input  bchn_pkg::cfg_t  cfg_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bchn_pkg::out_t  out_data_o
);
  import bchn_pkg::*;

  typedef enum logic [3:0] {
    ModePauseRelease   = 4'd0,
    ModeWaitPress      = 4'd1,
    ModeUnpauseRelease = 4'd2,
    ModeDrive          = 4'd3,
    ModeTurnLeft       = 4'd4,
    ModeTurnRight      = 4'd5,
    ModeTurnLeftHome   = 4'd6,
    ModeTurnRightHome  = 4'd7,
    ModeReverse        = 4'd8,
    ModeRevTurnLeft    = 4'd9,
    ModeRevTurnRight   = 4'd10
  } mode_e;

  mode_e                    mode_q, mode_d, resume_q, resume_d;
  logic signed [31:0]       start_dist_q, start_dist_d;
  logic signed [15:0]       start_head_q, start_head_d;
  logic [LegW-1:0]          leg_q, leg_d;
  logic signed [SteerW-1:0] steer_q, steer_d;
  logic                     out_valid_q;
  out_t                     out_q, out_d;

  logic               advance;
  logic               mark;
  logic               any_bump, any_cliff, head_neg;
  logic signed [32:0] dist_diff;
  logic [32:0]        dmag;
  logic [16:0]        hmag, turned;
  logic signed [16:0] head_diff, perp;
  logic [16:0]        pmag;
  logic signed [15:0] para;
  logic               perp_pos, perp_neg, para_pos, para_neg;
  logic               dist_done, head_off;
  logic signed [SteerW-1:0] off_pos, off_neg;
  logic signed [15:0] drive16, turn16, steer16;

  assign advance      = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_ready_o = advance;

  // Differences are formed one bit wider so that they cannot wrap.
  assign dist_diff = {item_i.travelled_mm[31], item_i.travelled_mm}
                   - {start_dist_q[31], start_dist_q};
  assign dmag      = dist_diff[32] ? 33'(-dist_diff) : 33'(dist_diff);
  assign hmag      = item_i.heading_deg[15] ? 17'(-{1'b1, item_i.heading_deg})
                                            : {1'b0, item_i.heading_deg};
  assign head_diff = {item_i.heading_deg[15], item_i.heading_deg}
                   - {start_head_q[15], start_head_q};
  assign turned    = head_diff[16] ? 17'(-head_diff) : 17'(head_diff);

  assign perp = cfg_i.axis_mapping ? {item_i.accel_x[15], item_i.accel_x}
                                   : 17'(17'sd0 - {item_i.accel_y[15], item_i.accel_y});
  assign para = cfg_i.axis_mapping ? item_i.accel_y : item_i.accel_x;
  assign pmag = perp[16] ? 17'(-perp) : 17'(perp);
  assign perp_pos = !perp[16] && (perp != 17'sd0);
  assign perp_neg = perp[16];
  assign para_pos = !para[15] && (para != 16'sd0);
  assign para_neg = para[15];

  assign any_bump  = item_i.bump_left || item_i.bump_center || item_i.bump_right;
  assign any_cliff = item_i.cliff_left || item_i.cliff_center || item_i.cliff_right;
  assign head_neg  = item_i.heading_deg[15];
  assign dist_done = dmag >= {19'd0, leg_q};
  assign head_off  = hmag >= {9'd0, cfg_i.heading_tolerance};
  assign off_pos   = {2'b00, cfg_i.steer_offset};
  assign off_neg   = SteerW'(-off_pos);

  always_comb begin
    mode_d       = mode_q;
    resume_d     = resume_q;
    leg_d        = leg_q;
    steer_d      = steer_q;
    start_dist_d = start_dist_q;
    start_head_d = start_head_q;
    mark         = 1'b0;

    if (mode_q == ModePauseRelease || mode_q == ModeWaitPress ||
        mode_q == ModeUnpauseRelease || item_i.pause_button) begin
      unique case (mode_q)
        ModePauseRelease:   if (!item_i.pause_button) mode_d = ModeWaitPress;
        ModeUnpauseRelease: if (!item_i.pause_button) mode_d = resume_q;
        ModeWaitPress:      if (item_i.pause_button) mode_d = ModeUnpauseRelease;
        default: begin
          resume_d = mode_q;
          mode_d   = ModePauseRelease;
        end
      endcase
    end else begin
      unique case (mode_q)
        ModeDrive: begin
          priority if (any_cliff) begin
            mark = 1'b1;
            priority if (item_i.cliff_left) begin
              mode_d = ModeRevTurnRight;
              leg_d  = CliffBackupMm;
            end else if (item_i.cliff_right) begin
              mode_d = ModeRevTurnLeft;
              leg_d  = CliffBackupMm;
            end else begin
              mode_d = head_neg ? ModeRevTurnRight : ModeRevTurnLeft;
              leg_d  = {4'd0, cfg_i.reverse_distance};
            end
          end else if (any_bump) begin
            mark = 1'b1;
            // A second bump before the avoidance leg is done backs off instead.
            if (leg_q == LegTargetAvoid) begin
              mode_d = ModeReverse;
              leg_d  = {4'd0, cfg_i.reverse_distance};
            end else begin
              priority if (item_i.bump_left) mode_d = ModeTurnRight;
              else if (item_i.bump_right) mode_d = ModeTurnLeft;
              else mode_d = head_neg ? ModeTurnLeft : ModeTurnRight;
              leg_d = LegTargetAvoid;
            end
          end else if (dist_done && head_off) begin
            mark   = 1'b1;
            mode_d = head_neg ? ModeTurnLeftHome : ModeTurnRightHome;
            leg_d  = LegTargetMax;
          end else if (pmag >= {2'b00, cfg_i.slope_enter_level}) begin
            if (para_pos) begin
              if (perp_pos) steer_d = off_pos;
              else if (perp_neg) steer_d = off_neg;
            end else if (para_neg) begin
              if (perp_pos) steer_d = off_neg;
              else if (perp_neg) steer_d = off_pos;
            end
          end
          // The exit test runs even on a tick that leaves drive.
          if (pmag < {2'b00, cfg_i.slope_exit_level}) steer_d = '0;
        end
        ModeTurnLeft, ModeTurnRight: begin
          if (turned >= TurnDegrees) begin
            mark   = 1'b1;
            mode_d = ModeDrive;
          end
        end
        ModeTurnLeftHome, ModeTurnRightHome: begin
          if (!head_off) begin
            mark   = 1'b1;
            mode_d = ModeDrive;
          end
        end
        ModeReverse: begin
          if (dist_done) begin
            mark   = 1'b1;
            mode_d = head_neg ? ModeTurnLeftHome : ModeTurnRightHome;
            leg_d  = LegTargetMax;
          end
        end
        ModeRevTurnLeft, ModeRevTurnRight: begin
          if (dist_done) begin
            mark   = 1'b1;
            mode_d = (mode_q == ModeRevTurnLeft) ? ModeTurnLeft : ModeTurnRight;
            leg_d  = LegTargetAvoid;
          end
        end
        default: begin
          if (any_bump || any_cliff) begin
            resume_d = ModeDrive;
            mode_d   = ModePauseRelease;
            leg_d    = LegTargetMax;
          end
        end
      endcase
    end

    if (mark) begin
      start_dist_d = item_i.travelled_mm;
      start_head_d = item_i.heading_deg;
    end
  end

  assign drive16 = {6'd0, cfg_i.cruise_speed};
  assign turn16  = {6'd0, cfg_i.spin_speed};
  assign steer16 = {{(16 - SteerW){steer_d[SteerW-1]}}, steer_d};

  always_comb begin
    out_d.left_wheel_speed  = '0;
    out_d.right_wheel_speed = '0;
    out_d.mode_code         = mode_d;
    unique case (mode_d)
      ModeDrive: begin
        out_d.left_wheel_speed  = drive16 + steer16;
        out_d.right_wheel_speed = drive16 - steer16;
      end
      ModeTurnLeft, ModeTurnLeftHome: begin
        out_d.left_wheel_speed  = 16'sd0 - turn16;
        out_d.right_wheel_speed = turn16;
      end
      ModeTurnRight, ModeTurnRightHome: begin
        out_d.left_wheel_speed  = turn16;
        out_d.right_wheel_speed = 16'sd0 - turn16;
      end
      ModeReverse, ModeRevTurnLeft, ModeRevTurnRight: begin
        out_d.left_wheel_speed  = 16'sd0 - drive16;
        out_d.right_wheel_speed = 16'sd0 - drive16;
      end
      default: begin
        out_d.left_wheel_speed  = '0;
        out_d.right_wheel_speed = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeWaitPress;
      resume_q     <= ModeDrive;
      start_dist_q <= '0;
      start_head_q <= '0;
      leg_q        <= LegTargetMax;
      steer_q      <= '0;
      out_valid_q  <= 1'b0;
    end else if (advance) begin
      mode_q       <= mode_d;
      resume_q     <= resume_d;
      start_dist_q <= start_dist_d;
      start_head_q <= start_head_d;
      leg_q        <= leg_d;
      steer_q      <= steer_d;
      out_valid_q  <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/bump_cliff_hill_navigation_fsm_core.sv
// Top level of the bump, cliff and hill navigation controller.
// Instantiates bchn_cfg_regs and bchn_ctrl; depends on bchn_pkg.
//
// Usage:
//   Each input beat on in_data_i is one control tick: pause button, bump and
//   cliff switches, odometry distance and heading, and two accelerometer
//   axes. Each tick gives exactly one result beat on out_data_o with both
//   wheel speeds and the mode code after the tick.
//   Both channels use valid/ready. A beat is first captured in an input
//   register and is then worked in a single pass into the result register,
//   which drives out_valid_o and out_data_o. Throughput is one beat per
//   cycle while the receiver takes results; it is set by the state update,
//   which finishes in the cycle a tick leaves the input register.
//   When the receiver stalls, the result register holds its beat, the
//   input register fills, and in_ready_o falls only once both are full.
//   The configuration port writes one register per cycle with cfg_we_i;
//   the user must make writes only while no tick is in flight; the block
//   itself does not enforce this.
//   Reset clears the configuration to its defaults, puts the controller in
//   the wait-for-press mode with drive as the resume mode, and empties both
//   registers.
module bump_cliff_hill_navigation_fsm_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bchn_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bchn_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [bchn_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bchn_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import bchn_pkg::*;

  cfg_t cfg;
  in_t  item_q;
  logic item_valid_q;
  logic item_ready;

  assign in_ready_o = !item_valid_q || item_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      item_valid_q <= 1'b1;
    end else if (item_ready) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  bchn_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bchn_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid_q),
    .item_i       (item_q),
    .item_ready_o (item_ready),
    .cfg_i        (cfg),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

FILE: rtl/bchn_checker.sv
// Port-level checks for the navigation controller, bound to the top level.
// Depends on bchn_pkg and bump_cliff_hill_navigation_fsm_core.
module bchn_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input bchn_pkg::out_t                 out_data_o
);
  import bchn_pkg::*;

  // A result beat that is not taken stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // An accepted tick reaches the result through the input and result registers if not blocked.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 (!out_valid_o || out_ready_i) |=> out_valid_o)
    else $error("accepted tick did not produce a result in time");

  // Paused modes keep both wheels still.
  a_pause_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mode_code < ModeCodeDrive |->
      out_data_o.left_wheel_speed == 16'sd0 && out_data_o.right_wheel_speed == 16'sd0)
    else $error("wheels moving in a paused mode");

  // Only defined mode codes appear, and reversing drives both wheels alike.
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.mode_code <= ModeCodeLast &&
      (out_data_o.mode_code < ModeCodeReverse ||
       out_data_o.left_wheel_speed == out_data_o.right_wheel_speed))
    else $error("bad mode code or unequal wheels while reversing");

endmodule

bind bump_cliff_hill_navigation_fsm_core bchn_checker u_bchn_checker (.*);
